/* rtl/odi_pkg.sv */
// Shared types and constants for the planar odometry integrator.
// No dependencies; used by odi_cordic, odi_mac and the top level.
package odi_pkg;

  localparam int ACC_W   = 68;  // accumulator width
  localparam int MA_W    = 34;  // multiplier operand A, also CORDIC x/y width
  localparam int MB_W    = 18;  // multiplier operand B
  localparam int ATAN_N  = 24;
  localparam logic [31:0] CORDIC_ONE_GAIN = 32'd652032874;
  // 2^32 / (2 pi), split at bit 15
  localparam logic [MB_W-1:0] INV2PI_HI = 18'd20860;
  localparam logic [MB_W-1:0] INV2PI_LO = 18'd24796;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_15 = 2'd1,
    SH_24 = 2'd2
  } shift_t;

  typedef struct packed {
    logic             en;
    logic             clr;
    logic             neg;
    shift_t           sh;
    logic [ACC_W-1:0] init;
  } mac_op_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10680862;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/odi_cordic.sv */
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on odi_pkg (arctangent table, widths, gain constant).
module odi_cordic #(
  parameter int STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [31:0]                   angle,
  output logic                          done,
  output logic signed [odi_pkg::MA_W-1:0] sin_o,
  output logic signed [odi_pkg::MA_W-1:0] cos_o
);

  localparam int N = (STEPS < odi_pkg::ATAN_N) ? STEPS : odi_pkg::ATAN_N;
  localparam int W = odi_pkg::MA_W;

  logic signed [W-1:0] x_r, y_r, z_r;
  logic                flip_r, busy_r, done_r;
  logic [4:0]          cnt_r;
  logic [31:0]         a_rot;
  logic                flip;
  logic signed [W-1:0] dx, dy, at;

  assign flip  = angle[31] ^ angle[30];   // bit 31 of angle + quarter turn
  assign a_rot = flip ? (angle + 32'h8000_0000) : angle;
  assign dx    = y_r >>> cnt_r;
  assign dy    = x_r >>> cnt_r;
  assign at    = W'(odi_pkg::atan_lut(cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        flip_r <= flip;
        x_r    <= W'(odi_pkg::CORDIC_ONE_GAIN);
        y_r    <= '0;
        z_r    <= W'(signed'(a_rot));
      end else if (busy_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        if (cnt_r == 5'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 5'd1;
      end
    end
  end

  assign done  = done_r;
  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;

endmodule

/* rtl/odi_mac.sv */
// Shared multiply-accumulate: registered product, then shifted add into acc.
// Depends on odi_pkg (mac_op_t, shift codes, widths).
module odi_mac (
  input  logic                             clk,
  input  logic                             rst_n,
  input  odi_pkg::mac_op_t                 op,
  input  logic signed [odi_pkg::MA_W-1:0]  a,
  input  logic signed [odi_pkg::MB_W-1:0]  b,
  output logic signed [odi_pkg::ACC_W-1:0] acc
);

  localparam int PW = odi_pkg::MA_W + odi_pkg::MB_W;

  logic signed [PW-1:0]            prod_r;
  odi_pkg::mac_op_t                op_r;
  logic signed [odi_pkg::ACC_W-1:0] acc_r, term, base;

  always_comb begin
    term = odi_pkg::ACC_W'(prod_r);
    case (op_r.sh)
      odi_pkg::SH_0:  term = term;
      odi_pkg::SH_15: term = term <<< 15;
      odi_pkg::SH_24: term = term <<< 24;
      default:        term = term;
    endcase
    if (op_r.neg) term = -term;
    base = op_r.clr ? signed'(op_r.init) : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r.en <= 1'b0;
    end else begin
      op_r <= op;
      if (op.en) prod_r <= a * b;
      if (op_r.en) acc_r <= base + term;
    end
  end

  assign acc = acc_r;

endmodule

/* rtl/planar_odometry_integrator.sv */
// Planar dead-reckoning odometry top level; depends on odi_pkg, odi_cordic, odi_mac.
// Per tick: a CORDIC pass at the current heading, MAC steps that rotate and scale the
// velocity into x then y, the heading update, a second CORDIC pass, then the output load.
// A new tick is taken only once the last one is through: in_ready is high only while idle, and a
// pose still waiting on out_ready holds the next one at the output load.
// Synchronous active-low reset zeroes position and heading and clears out_valid.
module planar_odometry_integrator #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic signed [15:0] in_yaw_rate,
  input  logic        [15:0] in_elapsed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic        [15:0] out_heading,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w
);

  localparam int AW = odi_pkg::MA_W;
  localparam int BW = odi_pkg::MB_W;
  localparam int CW = odi_pkg::ACC_W;

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_CORD1 = 17'h00002,
    S_ROT0  = 17'h00004,
    S_ROT1  = 17'h00008,
    S_ROT2  = 17'h00010,
    S_SCL0  = 17'h00020,
    S_SCL1  = 17'h00040,
    S_SCL2  = 17'h00080,
    S_POS   = 17'h00100,
    S_HD0   = 17'h00200,
    S_HD1   = 17'h00400,
    S_HD2   = 17'h00800,
    S_HD3   = 17'h01000,
    S_HD4   = 17'h02000,
    S_HD5   = 17'h04000,
    S_CORD2 = 17'h08000,
    S_EMIT  = 17'h10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   sel_y_r;
  logic signed [15:0]     vx_r, vy_r, wz_r;
  logic        [15:0]     dt_r;
  logic signed [31:0]     pos_x_r, pos_y_r;
  logic [ANGLE_BITS-1:0]  heading_r;
  logic signed [47:0]     t_r;
  logic signed [31:0]     out_px_r, out_py_r;
  logic        [15:0]     out_hd_r;
  logic signed [15:0]     qz_r, qw_r;

  logic                   cd_start, cd_done;
  logic [31:0]            cd_angle, a32;
  logic signed [AW-1:0]   sn, cs;
  odi_pkg::mac_op_t       op;
  logic signed [AW-1:0]   ma;
  logic signed [BW-1:0]   mb, dt_b;
  logic signed [CW-1:0]   acc;
  logic signed [25:0]     delta;
  logic signed [32:0]     psum;
  logic signed [31:0]     psat, pcur;
  logic [ANGLE_BITS-1:0]  hd_new;
  logic                   emit_go;

  assign a32    = {heading_r, (32 - ANGLE_BITS)'(0)};
  assign dt_b   = BW'({1'b0, dt_r});
  assign hd_new = heading_r + acc[60-ANGLE_BITS +: ANGLE_BITS];

  odi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(cd_start), .angle(cd_angle), .done(cd_done),
    .sin_o(sn), .cos_o(cs)
  );

  odi_mac u_mac (.clk, .rst_n, .op, .a(ma), .b(mb), .acc);

  function automatic logic signed [15:0] quat_part(input logic signed [AW-1:0] v);
    logic signed [AW:0]  s;
    logic signed [AW-16:0] r;
    s = (AW+1)'(v) + (AW+1)'(32768);
    r = s[AW:16];
    if (r > 16384) r = (AW-15)'(16384);
    if (r < -16384) r = (AW-15)'(-16384);
    return 16'(r);
  endfunction

  // second pass runs at half the new heading
  logic cd2_go;
  assign cd2_go = (state_r == S_HD5);

  // MAC issue and CORDIC start per state
  always_comb begin
    op       = '0;
    ma       = '0;
    mb       = '0;
    cd_start = 1'b0;
    cd_angle = a32;
    case (state_r)
      S_IDLE: begin
        cd_start = in_valid;
      end
      S_ROT0: begin
        op.en = 1'b1; op.clr = 1'b1; op.sh = odi_pkg::SH_0;
        // x: vx*cos, y: vx*sin
        ma = sel_y_r ? sn : cs;
        mb = BW'(vx_r);
      end
      S_ROT1: begin
        op.en = 1'b1; op.neg = !sel_y_r; op.sh = odi_pkg::SH_0;
        ma = sel_y_r ? cs : sn;
        mb = BW'(vy_r);
      end
      S_SCL0: begin
        op.en = 1'b1; op.clr = 1'b1; op.sh = odi_pkg::SH_0;
        op.init = CW'(1) <<< 41;
        ma = AW'({1'b0, acc[23:0]});
        mb = dt_b;
      end
      S_SCL1: begin
        op.en = 1'b1; op.sh = odi_pkg::SH_24;
        ma = AW'(signed'(t_r[47:24]));
        mb = dt_b;
      end
      S_HD0: begin
        op.en = 1'b1; op.clr = 1'b1; op.sh = odi_pkg::SH_0;
        ma = AW'(wz_r);
        mb = dt_b;
      end
      S_HD2: begin
        op.en = 1'b1; op.clr = 1'b1; op.sh = odi_pkg::SH_0;
        op.init = CW'(1) <<< (59 - ANGLE_BITS);
        ma = acc[AW-1:0];
        mb = odi_pkg::INV2PI_LO;
      end
      S_HD3: begin
        op.en = 1'b1; op.sh = odi_pkg::SH_15;
        ma = t_r[AW-1:0];
        mb = odi_pkg::INV2PI_HI;
      end
      S_HD5: begin
        cd_start = cd2_go;
        cd_angle = {hd_new, (32 - ANGLE_BITS)'(0)} >> 1;
      end
      default: begin
        op = '0;
      end
    endcase
  end

  assign delta = acc[67:42];
  assign pcur  = sel_y_r ? pos_y_r : pos_x_r;
  assign psum  = 33'(pcur) + 33'(delta);
  always_comb begin
    if (psum > 33'sd2147483647)       psat = 32'sh7FFF_FFFF;
    else if (psum < -33'sd2147483648) psat = 32'sh8000_0000;
    else                              psat = psum[31:0];
  end

  // pose moves to the output register once the previous beat has left
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit_go) out_valid_nxt = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CORD1;
      S_CORD1: if (cd_done) state_nxt = S_ROT0;
      S_ROT0:  state_nxt = S_ROT1;
      S_ROT1:  state_nxt = S_ROT2;
      S_ROT2:  state_nxt = S_SCL0;
      S_SCL0:  state_nxt = S_SCL1;
      S_SCL1:  state_nxt = S_SCL2;
      S_SCL2:  state_nxt = S_POS;
      S_POS:   state_nxt = sel_y_r ? S_HD0 : S_ROT0;
      S_HD0:   state_nxt = S_HD1;
      S_HD1:   state_nxt = S_HD2;
      S_HD2:   state_nxt = S_HD3;
      S_HD3:   state_nxt = S_HD4;
      S_HD4:   state_nxt = S_HD5;
      S_HD5:   state_nxt = S_CORD2;
      S_CORD2: if (cd_done) state_nxt = S_EMIT;
      S_EMIT:  if (emit_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sel_y_r     <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            vx_r    <= in_vel_x;
            vy_r    <= in_vel_y;
            wz_r    <= in_yaw_rate;
            dt_r    <= in_elapsed;
            sel_y_r <= 1'b0;
          end
        end
        S_SCL0: t_r <= acc[47:0];
        S_HD2:  t_r <= acc[47:0];
        S_POS: begin
          if (sel_y_r) pos_y_r <= psat;
          else         pos_x_r <= psat;
          sel_y_r <= !sel_y_r;
        end
        S_HD5: heading_r <= hd_new;
        S_EMIT: begin
          if (emit_go) begin
            out_px_r <= pos_x_r;
            out_py_r <= pos_y_r;
            out_hd_r <= a32[31:16];
            qz_r     <= quat_part(sn);
            qw_r     <= quat_part(cs);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_pos_x   = out_px_r;
  assign out_pos_y   = out_py_r;
  assign out_heading = out_hd_r;
  assign out_quat_z  = qz_r;
  assign out_quat_w  = qw_r;

endmodule

/* tb/planar_odometry_integrator_test.sv */
// Self-checking testbench for planar_odometry_integrator: random ticks with
// random gaps on both channels, poses predicted by a local fixed-point model.
// Depends on the RTL top level and odi_pkg only through the DUT ports.
`timescale 1ns / 100ps

module planar_odometry_integrator_test;

  localparam int STEPS    = 16;
  localparam int ANG_BITS = 16;
  localparam int N_RAND   = 450;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] wz;
    logic        [15:0] dt;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic        [15:0] hd;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } pose_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [15:0] in_vel_x = 0, in_vel_y = 0, in_yaw_rate = 0;
  logic [15:0] in_elapsed = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] out_pos_x, out_pos_y;
  logic [15:0] out_heading;
  logic signed [15:0] out_quat_z, out_quat_w;

  planar_odometry_integrator #(.CORDIC_STEPS(STEPS), .ANGLE_BITS(ANG_BITS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .in_yaw_rate(in_yaw_rate), .in_elapsed(in_elapsed),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_heading(out_heading),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w)
  );

  tick_t pending_ticks[$];
  pose_t expected_poses[$];
  logic signed [31:0] pos_x_acc, pos_y_acc;
  logic [31:0] heading_acc;
  int mismatches = 0;
  bit stim_done = 0;
  bit in_taken = 0;
  bit out_taken = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint atan_val(int i);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10680862, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861, 10430, 5215,
                      2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  // sin/cos in Q2.30 of a 32-bit binary angle
  task automatic sin_cos(input logic [31:0] ang, output longint sn, output longint cs);
    logic [31:0] a;
    logic [31:0] tmp;
    bit flip;
    longint x, y, z, dx, dy;
    a = ang;
    tmp = a + 32'h40000000;
    flip = tmp[31];
    if (flip) a = a + 32'h80000000;
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_val(i);
      end else begin
        x += dx; y -= dy; z += atan_val(i);
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endtask

  function automatic logic signed [15:0] quat_part(longint v);
    longint r;
    r = round_shift(v, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  task automatic integrate_tick(input tick_t t);
    longint vx, vy, wz, dt, sn, cs, rx, ry, dth;
    logic [31:0] amask, a32;
    pose_t p;
    vx = t.vx; vy = t.vy; wz = t.wz; dt = longint'({1'b0, t.dt});
    amask = (32'd1 << ANG_BITS) - 32'd1;
    a32 = (heading_acc & amask) << (32 - ANG_BITS);
    sin_cos(a32, sn, cs);
    rx = vx * cs - vy * sn;
    ry = vx * sn + vy * cs;
    pos_x_acc = sat32(longint'(pos_x_acc) + round_shift(rx * dt, 42));
    pos_y_acc = sat32(longint'(pos_y_acc) + round_shift(ry * dt, 42));
    dth = round_shift(wz * dt * 64'sd683565276, 60 - ANG_BITS);
    heading_acc = (heading_acc + dth[31:0]) & amask;
    a32 = heading_acc << (32 - ANG_BITS);
    sin_cos(a32 >> 1, sn, cs);
    p.px = pos_x_acc;
    p.py = pos_y_acc;
    p.hd = a32[31:16];
    p.qz = quat_part(sn);
    p.qw = quat_part(cs);
    expected_poses.push_back(p);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 31));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_tick(input logic [15:0] vx, vy, wz, dt);
    tick_t t;
    t.vx = vx; t.vy = vy; t.wz = wz; t.dt = dt;
    pending_ticks.push_back(t);
  endtask

  initial begin
    // directed: zero elapsed, extremes, spin past a full turn, a run of full-speed ticks
    add_tick(16'h7fff, 16'h7fff, 16'h7fff, 16'h0000);
    add_tick(16'h1000, 16'h0000, 16'h0000, 16'hffff);
    add_tick(16'h0000, 16'h1000, 16'h0000, 16'hffff);
    add_tick(16'h8000, 16'h8000, 16'h8000, 16'hffff);
    add_tick(16'h7fff, 16'h0000, 16'h7fff, 16'hffff);
    add_tick(16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
    add_tick(16'h0000, 16'h0000, 16'h7fff, 16'hffff);
    add_tick(16'h0000, 16'h0000, 16'h8000, 16'hffff);
    add_tick(16'h0000, 16'h0000, 16'h8000, 16'hffff);
    add_tick(16'h0000, 16'h0000, 16'h0001, 16'h0001);
    add_tick(16'hffff, 16'h0001, 16'hffff, 16'h0001);
    add_tick(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    add_tick(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    for (int i = 0; i < 10; i++) add_tick(16'h7fff, 16'h7fff, 16'h0000, 16'hffff);
    for (int i = 0; i < N_RAND; i++)
      add_tick(rand_field(), rand_field(), rand_field(), rand_field());
  end

  // driver: reacts to the beats seen at the previous rising edge
  int in_gap = 0;
  int out_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_valid <= 0;
        in_gap = gap_len();
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap--;
        else if (pending_ticks.size() > 0) begin
          tick_t t;
          t = pending_ticks.pop_front();
          in_vel_x <= t.vx; in_vel_y <= t.vy;
          in_yaw_rate <= t.wz; in_elapsed <= t.dt;
          in_valid <= 1;
        end else stim_done = 1;
      end
      if (out_taken) begin
        out_gap = gap_len();
        if (out_gap > 0) out_ready <= 0;
      end else if (!out_ready) begin
        if (out_gap > 0) out_gap--;
        else out_ready <= 1;
      end
    end
  end

  // monitor: accepted ticks feed the predictor, accepted poses get checked
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    out_taken = rst_n && out_valid && out_ready;
    if (rst_n) begin
      if (in_valid && in_ready)
        integrate_tick({in_vel_x, in_vel_y, in_yaw_rate, in_elapsed});
      if (out_valid && out_ready) begin
        pose_t got, exp_p;
        got = {out_pos_x, out_pos_y, out_heading, out_quat_z, out_quat_w};
        if (expected_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pose beat: %p", got);
        end else begin
          exp_p = expected_poses.pop_front();
          if (got !== exp_p) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pose mismatch: expected %p got %p", exp_p, got);
          end
        end
      end
    end
  end

  initial begin
    pos_x_acc = 0; pos_y_acc = 0; heading_acc = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    wait (stim_done && !in_valid && expected_poses.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_poses.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
rtl/odi_pkg.sv
rtl/odi_cordic.sv
rtl/odi_mac.sv
rtl/planar_odometry_integrator.sv
tb/planar_odometry_integrator_test.sv
